// File: rtl/core/union_find_kruskal_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the union-find engine
// Shared property wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_KRUSKAL_ENGINE_ASSERT_SVH
`define UNION_FIND_KRUSKAL_ENGINE_ASSERT_SVH

// same-cycle implication
`define UFK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ufk assertion failed");

// next-cycle implication
`define UFK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ufk assertion failed");

`endif

// File: rtl/core/ufk_pkg.sv
// ----------------------------------------------------------------------------
// ufk_pkg
// Types and constants of the union-find / Kruskal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ufk_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int WEIGHT_W  = 16;
    localparam int SUM_W     = 32;

    localparam logic [1:0] FUNC_UNION = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_EDGE  = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_ufk_in;

    typedef struct packed {
        logic               were_joined;
        logic               merged;
        logic [CNT_W-1:0]   groups_left;
        logic [SUM_W-1:0]   tree_weight;
        logic               bad_node;
    } t_ufk_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_CHASE,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_LINK,
        ST_DONE
    } t_ufk_state;

endpackage

`default_nettype wire

// File: rtl/core/union_find_kruskal_engine.sv
// ----------------------------------------------------------------------------
// union_find_kruskal_engine
// Disjoint-set engine with path compression and Kruskal weight sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_in_data (func, node_a,
//   node_b, edge_weight). Output channel: o_out_valid / i_out_stall with
//   o_out_data. One result beat per input beat, in order.
//   i_cfg_we / i_cfg_wdata write node_count; the write reinitializes the
//   link table, the group count and the weight sum.
//   One item at a time. A find issues a read of the start node, chases
//   links until a node that links to itself, compares, and writes the
//   root back into every link on the path. An item is the accept step,
//   two finds, one link step and one result step; bad nodes and unused
//   codes go from the accept step straight to the result step. The link
//   memory takes one read and one write per cycle.
//   After reset and every node_count write, a clearing pass over all 1024
//   entries restores the identity table; o_in_stall stays high meanwhile.
//   A finished result sits in the output register while the next beat is
//   taken; if i_out_stall holds it, the engine waits only at its own
//   result state.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_kruskal_engine
    import ufk_pkg::*;
`include "union_find_kruskal_engine_assert.svh"
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire t_ufk_in          i_in_data,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      t_ufk_out         o_out_data
);

    logic [NODE_W-1:0] r_link_mem [MAX_NODES];
    logic [NODE_W-1:0] r_rdata;

    t_ufk_state        r_state, n_state;
    t_ufk_in           r_item, n_item;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_root, n_root;
    logic [NODE_W-1:0] r_root_a, n_root_a;
    logic              r_side, n_side;
    logic              r_joined, n_joined;
    logic              r_merged, n_merged;
    logic              r_bad, n_bad;
    logic [CNT_W-1:0]  r_node_cnt;
    logic [CNT_W-1:0]  r_groups, n_groups;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic              r_clearing;
    logic [NODE_W-1:0] r_clr_idx;
    logic              r_out_valid;
    t_ufk_out          r_out;

    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [NODE_W-1:0] wr_data;
    logic              in_take;
    logic              out_free;
    logic              out_load;
    logic              path_end;
    logic              item_bad;
    logic [SUM_W:0]    sum_ext;
    logic [CNT_W-1:0]  cfg_eff;

    assign o_in_stall  = (r_state != ST_IDLE) || r_clearing;
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign item_bad = ({1'b0, i_in_data.node_a} >= r_node_cnt)
                   || ({1'b0, i_in_data.node_b} >= r_node_cnt);
    assign sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(r_item.edge_weight);
    assign cfg_eff  = (i_cfg_wdata == '0) ? CNT_W'(1)
                    : (i_cfg_wdata > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                    : i_cfg_wdata;

    // compression reaches the root on this cycle
    always_comb begin
        path_end = 1'b0;
        case (r_state)
            ST_CMP_RD: path_end = (r_cur == r_root);
            ST_CMP_WR: path_end = (r_rdata == r_root);
            default:   path_end = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (item_bad || (i_in_data.func != FUNC_UNION
                            && i_in_data.func != FUNC_QUERY
                            && i_in_data.func != FUNC_EDGE)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_FIND;
                    end
                end
            end
            ST_FIND: n_state = ST_CHASE;
            ST_CHASE: begin
                if (r_rdata == r_cur) begin
                    n_state = ST_CMP_RD;
                end
            end
            ST_CMP_RD: begin
                if (path_end) begin
                    n_state = r_side ? ST_LINK : ST_FIND;
                end else begin
                    n_state = ST_CMP_WR;
                end
            end
            ST_CMP_WR: begin
                if (path_end) begin
                    n_state = r_side ? ST_LINK : ST_FIND;
                end
            end
            ST_LINK: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_item   = r_item;
        n_cur    = r_cur;
        n_root   = r_root;
        n_root_a = r_root_a;
        n_side   = r_side;
        n_joined = r_joined;
        n_merged = r_merged;
        n_bad    = r_bad;
        n_groups = r_groups;
        n_sum    = r_sum;
        rd_addr  = r_cur;
        wr_en    = 1'b0;
        wr_addr  = r_cur;
        wr_data  = r_root;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_item   = i_in_data;
                    n_cur    = i_in_data.node_a;
                    n_side   = 1'b0;
                    n_joined = 1'b0;
                    n_merged = 1'b0;
                    n_bad    = item_bad;
                end
            end
            ST_CHASE: begin
                if (r_rdata == r_cur) begin
                    n_root = r_cur;
                    n_cur  = r_side ? r_item.node_b : r_item.node_a;
                end else begin
                    n_cur   = r_rdata;
                    rd_addr = r_rdata;
                end
            end
            ST_CMP_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_root;
                if (!path_end) begin
                    n_cur   = r_rdata;
                    rd_addr = r_rdata;
                end
            end
            ST_LINK: begin
                n_joined = (r_root_a == r_root);
                if ((r_root_a != r_root) && (r_item.func != FUNC_QUERY)) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_root;
                    wr_data  = r_root_a;
                    n_merged = 1'b1;
                    if (r_groups != '0) begin
                        n_groups = r_groups - CNT_W'(1);
                    end
                    if (r_item.func == FUNC_EDGE) begin
                        n_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    end
                end
            end
            ST_DONE: out_load = out_free;
            default: ;
        endcase
        if (path_end && !r_side) begin
            n_root_a = r_root;
            n_side   = 1'b1;
            n_cur    = r_item.node_b;
        end
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = r_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_link_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_cur    <= n_cur;
        r_root   <= n_root;
        r_root_a <= n_root_a;
        r_side   <= n_side;
        r_joined <= n_joined;
        r_merged <= n_merged;
        r_bad    <= n_bad;
        if (out_load) begin
            r_out.were_joined <= r_joined;
            r_out.merged      <= r_merged;
            r_out.groups_left <= r_groups;
            r_out.tree_weight <= (r_groups > CNT_W'(1)) ? '0 : r_sum;
            r_out.bad_node    <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_node_cnt  <= CNT_W'(MAX_NODES);
            r_groups    <= CNT_W'(MAX_NODES);
            r_sum       <= '0;
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_cnt <= cfg_eff;
                r_groups   <= cfg_eff;
                r_sum      <= '0;
                r_clearing <= 1'b1;
                r_clr_idx  <= '0;
            end else begin
                r_groups <= n_groups;
                r_sum    <= n_sum;
                if (r_clearing) begin
                    r_clr_idx <= r_clr_idx + NODE_W'(1);
                    if (r_clr_idx == NODE_W'(MAX_NODES - 1)) begin
                        r_clearing <= 1'b0;
                    end
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `UFK_ASSERT_NOW(a_clear_blocks_input, i_clk, i_rst_n, r_clearing, o_in_stall)
    `UFK_ASSERT_NOW(a_groups_bounded, i_clk, i_rst_n, 1'b1, r_groups <= r_node_cnt)
    `UFK_ASSERT_NOW(a_merge_not_joined, i_clk, i_rst_n, o_out_valid,
        !(o_out_data.merged && o_out_data.were_joined))
    `UFK_ASSERT_NOW(a_bad_no_merge, i_clk, i_rst_n, o_out_valid && o_out_data.bad_node,
        !o_out_data.merged && !o_out_data.were_joined)
    `UFK_ASSERT_NEXT(a_take_leaves_idle, i_clk, i_rst_n, in_take && !i_cfg_we,
        r_state != ST_IDLE)

endmodule

`default_nettype wire
